// File: rtl/psi_pkg.sv
// Package for the path sample interpolator: item types, register indexes and widths.
// It has no dependencies. The core module in this folder imports it.
`default_nettype none
package psi_pkg;

  localparam int DEF_MAX_POINTS = 64;
  localparam int LEN_W          = 31;
  localparam int CNT_W          = 7;
  localparam int FRAC_W         = 16;
  localparam int CFG_IDX_W      = 2;

  localparam logic [CFG_IDX_W-1:0] REG_POINT_COUNT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOTAL_LENGTH = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CLOSED_LOOP  = 2'd2;

  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  typedef struct packed {
    logic               op;
    logic [5:0]         index;
    logic signed [31:0] pos_x;
    logic signed [31:0] pos_y;
    logic signed [31:0] pos_z;
    logic [15:0]        ideal_speed;
    logic [15:0]        track_width;
    logic               braking;
    logic               accel;
    logic [3:0]         gear;
    logic signed [31:0] distance;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] out_x;
    logic signed [31:0] out_y;
    logic signed [31:0] out_z;
    logic [15:0]        out_speed;
    logic [15:0]        out_width;
    logic               out_braking;
    logic               out_accel;
    logic [3:0]         out_gear;
    logic               table_empty;
  } out_item_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [15:0] speed;
    logic [15:0] width;
    logic [5:0]  flag_gear;
  } sample_t;

endpackage
`default_nettype wire

// File: rtl/path_sample_interpolator_core.sv
// Top level of the path sample interpolator: sample memory, serial divider and lerp unit.
// It depends on psi_pkg for the item types, register indexes and widths.
//
// Channel | Ports                           | Moves
// input   | in_valid, in_ready, in_data     | one write or query item
// result  | out_valid, out_ready, out_data  | one interpolated sample per query
// config  | cfg_we, cfg_index, cfg_wdata    | one register write
//
// A write item is stored without leaving the idle state. A query runs the serial divider
// (DIVW = 47 + clog2(MAX_POINTS + 1) bits), which yields one quotient bit per cycle,
// first to wrap the distance in a closed loop, then for index and fraction. It reads twice
// on the single memory port and lerps each field on the shared multiplier. A zero length
// skips the divider; an empty table skips to the result. The sample memory is not cleared.
// Reset is synchronous and clears control state. A result held by out_ready stalls
// the next query only at its final step; items are taken while the result waits.
`default_nettype none
module path_sample_interpolator_core #(
  parameter int MAX_POINTS = psi_pkg::DEF_MAX_POINTS
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire psi_pkg::in_item_t                   in_data,
  output logic                                     out_valid,
  input  wire logic                                out_ready,
  output psi_pkg::out_item_t                       out_data,
  input  wire logic                                cfg_we,
  input  wire logic [psi_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  wire logic [psi_pkg::LEN_W-1:0]           cfg_wdata
);
  import psi_pkg::*;

  localparam int AW   = $clog2(MAX_POINTS);
  localparam int NW   = $clog2(MAX_POINTS + 1);
  localparam int DNW  = LEN_W + NW;
  localparam int DIVW = DNW + FRAC_W;
  localparam int QW   = NW + FRAC_W;
  localparam int ITW  = $clog2(DIVW + 1);

  typedef enum logic [3:0] {
    ST_IDLE, ST_MOD, ST_MULN, ST_DIV, ST_IDX, ST_RD_LO, ST_RD_HI, ST_RD_DONE,
    ST_MUL, ST_ADD, ST_OUT
  } state_t;

  state_t              state_r;
  logic [CNT_W-1:0]    count_r;
  logic [LEN_W-1:0]    len_r;
  logic                loop_r;
  logic                neg_r;
  logic signed [31:0]  dist_r;
  logic [LEN_W-1:0]    d_r;
  logic [NW-1:0]       n_r;
  logic [DNW-1:0]      dn_r;
  logic [DIVW-1:0]     dvd_r;
  logic [LEN_W-1:0]    rem_r;
  logic [QW-1:0]       quo_r;
  logic [ITW-1:0]      iter_r;
  logic [AW-1:0]       lo_r;
  logic [AW-1:0]       hi_r;
  logic [FRAC_W:0]     alpha_r;
  logic                empty_r;
  sample_t             lo_data_r;
  sample_t             hi_data_r;
  logic [2:0]          fld_r;
  logic signed [50:0]  prod_r;
  logic [31:0]         res_r [5];
  logic                out_valid_r;
  out_item_t           out_data_r;

  sample_t             mem [MAX_POINTS];
  sample_t             rdata_r;
  logic                rd_en;
  logic [AW-1:0]       rd_addr;
  logic                wr_en;
  sample_t             wr_data;

  logic                in_acc;
  logic [NW-1:0]       n_eff;
  logic [31:0]         abs_dist;
  logic [31:0]         rem_sh;
  logic                ge;
  logic [LEN_W-1:0]    rem_nxt;
  logic [NW-1:0]       q_n;
  logic [NW-1:0]       nm1;
  logic [NW-1:0]       lo_n;
  logic [NW-1:0]       lo_inc;
  logic [NW-1:0]       hi_n;
  logic signed [32:0]  a_s;
  logic signed [32:0]  b_s;
  logic signed [32:0]  diff_s;
  logic signed [50:0]  delta_s;
  sample_t             near;
  out_item_t           result;

  assign in_ready  = (state_r == ST_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign n_eff = (32'(count_r) > 32'(MAX_POINTS)) ? NW'(MAX_POINTS) : NW'(count_r);
  assign abs_dist = in_data.distance[31] ? 32'(-in_data.distance) : 32'(in_data.distance);

  assign rem_sh  = {rem_r, dvd_r[DIVW-1]};
  assign ge      = rem_sh >= {1'b0, len_r};
  assign rem_nxt = ge ? LEN_W'(rem_sh - {1'b0, len_r}) : rem_sh[LEN_W-1:0];

  assign q_n    = quo_r[QW-1:FRAC_W];
  assign nm1    = n_r - NW'(1);
  assign lo_n   = (!loop_r && q_n > nm1) ? nm1 : q_n;
  assign lo_inc = lo_n + NW'(1);
  assign hi_n   = loop_r ? ((lo_inc == n_r) ? NW'(0) : lo_inc)
                         : ((lo_inc > nm1) ? nm1 : lo_inc);

  always_comb begin
    case (fld_r)
      3'd0: begin
        a_s = {lo_data_r.x[31], lo_data_r.x};
        b_s = {hi_data_r.x[31], hi_data_r.x};
      end
      3'd1: begin
        a_s = {lo_data_r.y[31], lo_data_r.y};
        b_s = {hi_data_r.y[31], hi_data_r.y};
      end
      3'd2: begin
        a_s = {lo_data_r.z[31], lo_data_r.z};
        b_s = {hi_data_r.z[31], hi_data_r.z};
      end
      3'd3: begin
        a_s = {17'd0, lo_data_r.speed};
        b_s = {17'd0, hi_data_r.speed};
      end
      default: begin
        a_s = {17'd0, lo_data_r.width};
        b_s = {17'd0, hi_data_r.width};
      end
    endcase
  end

  assign diff_s  = b_s - a_s;
  assign delta_s = (prod_r + 51'sd32768) >>> FRAC_W;
  assign near    = (alpha_r < 17'd32768) ? lo_data_r : hi_data_r;

  always_comb begin
    result = '0;
    if (empty_r) begin
      result.table_empty = 1'b1;
    end else begin
      result.out_x       = res_r[0];
      result.out_y       = res_r[1];
      result.out_z       = res_r[2];
      result.out_speed   = res_r[3][15:0];
      result.out_width   = res_r[4][15:0];
      result.out_braking = near.flag_gear[0];
      result.out_accel   = near.flag_gear[1];
      result.out_gear    = near.flag_gear[5:2];
    end
  end

  assign wr_en   = in_acc && (in_data.op == OP_WRITE) && (32'(in_data.index) < 32'(MAX_POINTS));
  assign wr_data = '{x: in_data.pos_x, y: in_data.pos_y, z: in_data.pos_z,
                     speed: in_data.ideal_speed, width: in_data.track_width,
                     flag_gear: {in_data.gear, in_data.accel, in_data.braking}};
  assign rd_en   = (state_r == ST_RD_LO) || (state_r == ST_RD_HI);
  assign rd_addr = (state_r == ST_RD_LO) ? lo_r : hi_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[AW'(in_data.index)] <= wr_data;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
      len_r   <= '0;
      loop_r  <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_POINT_COUNT:  count_r <= cfg_wdata[CNT_W-1:0];
        REG_TOTAL_LENGTH: len_r   <= cfg_wdata;
        REG_CLOSED_LOOP:  loop_r  <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_valid_r && out_ready && state_r != ST_OUT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        ST_IDLE: begin
          if (in_acc && in_data.op == OP_QUERY) begin
            n_r     <= n_eff;
            dist_r  <= in_data.distance;
            neg_r   <= in_data.distance[31];
            empty_r <= 1'b0;
            rem_r   <= '0;
            iter_r  <= '0;
            dvd_r   <= {abs_dist, (DIVW-32)'(0)};
            if (n_eff == '0) begin
              empty_r <= 1'b1;
              state_r <= ST_OUT;
            end else if (len_r == '0) begin
              lo_r    <= '0;
              hi_r    <= '0;
              alpha_r <= '0;
              state_r <= ST_RD_LO;
            end else if (loop_r) begin
              state_r <= ST_MOD;
            end else begin
              if (in_data.distance[31]) begin
                d_r <= '0;
              end else if (in_data.distance[30:0] > len_r) begin
                d_r <= len_r;
              end else begin
                d_r <= in_data.distance[30:0];
              end
              state_r <= ST_MULN;
            end
          end
        end
        ST_MOD: begin
          rem_r  <= rem_nxt;
          dvd_r  <= dvd_r << 1;
          iter_r <= iter_r + ITW'(1);
          if (iter_r == ITW'(31)) begin
            if (neg_r && rem_nxt != '0) begin
              d_r <= len_r - rem_nxt;
            end else begin
              d_r <= rem_nxt;
            end
            state_r <= ST_MULN;
          end
        end
        ST_MULN: begin
          dn_r    <= DNW'(d_r * n_r);
          state_r <= ST_DIV;
          iter_r  <= '0;
          rem_r   <= '0;
          quo_r   <= '0;
          if (iter_r != '0) begin
            state_r <= ST_MULN;
            iter_r  <= '0;
          end
        end
        ST_DIV: begin
          if (iter_r == '0 && dvd_r != {dn_r, FRAC_W'(0)}) begin
            dvd_r <= {dn_r, FRAC_W'(0)};
          end else begin
            rem_r   <= rem_nxt;
            dvd_r   <= dvd_r << 1;
            quo_r   <= {quo_r[QW-2:0], ge};
            iter_r  <= iter_r + ITW'(1);
            if (iter_r == ITW'(DIVW - 1)) begin
              state_r <= ST_IDX;
            end
          end
        end
        ST_IDX: begin
          lo_r    <= AW'(lo_n);
          hi_r    <= AW'(hi_n);
          alpha_r <= (!loop_r && q_n > nm1) ? (FRAC_W+1)'(1 << FRAC_W)
                                            : {1'b0, quo_r[FRAC_W-1:0]};
          state_r <= ST_RD_LO;
        end
        ST_RD_LO: begin
          state_r <= ST_RD_HI;
        end
        ST_RD_HI: begin
          lo_data_r <= rdata_r;
          state_r   <= ST_RD_DONE;
        end
        ST_RD_DONE: begin
          hi_data_r <= rdata_r;
          fld_r     <= '0;
          state_r   <= ST_MUL;
        end
        ST_MUL: begin
          prod_r  <= 51'(diff_s * $signed({1'b0, alpha_r}));
          state_r <= ST_ADD;
        end
        ST_ADD: begin
          res_r[fld_r] <= a_s[31:0] + delta_s[31:0];
          fld_r        <= fld_r + 3'd1;
          state_r      <= (fld_r == 3'd4) ? ST_OUT : ST_MUL;
        end
        ST_OUT: begin
          if (!out_valid_r || out_ready) begin
            out_valid_r <= 1'b1;
            out_data_r  <= result;
            state_r     <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  a_write_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_data.op == OP_WRITE) |=> (state_r == ST_IDLE))
    else $error("write item did not complete in one cycle");

  a_alpha_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MUL) |-> (alpha_r <= 17'd65536))
    else $error("fraction above one");

  a_result_from_out: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == ST_OUT))
    else $error("result raised outside the output step");

  a_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_RD_LO && !empty_r) |-> (32'(lo_r) < 32'(n_r) && 32'(hi_r) < 32'(n_r)))
    else $error("sample index beyond the table");

  a_dist_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOD) |=> $stable(dist_r))
    else $error("query distance changed during the wrap");

endmodule
`default_nettype wire
